// ===== hdl/pta_pkg.sv =====
package pta_pkg;

    // field and datapath widths
    localparam int DATA_W     = 16;
    localparam int ERR_W      = 17;
    localparam int SUM_W      = 18;
    localparam int INTEG_W    = 48;
    localparam int ACC_W      = 60;
    localparam int OUT_W      = 32;
    localparam int HIT_W      = 2;
    localparam int CFG_ADDR_W = 2;

    // shared serial multiplier: wide signed operand times a 17-bit signed operand
    localparam int MUL_A_W    = 48;
    localparam int MUL_B_W    = 17;
    localparam int MUL_P_W    = 65;
    localparam int MUL_DIG_W  = 4;
    localparam int MUL_DIGITS = 5;

    // serial divider: 17-bit magnitude scaled by 2^16, over a 16-bit divisor
    localparam int DIV_MAG_W  = 17;
    localparam int DIV_Q_W    = 33;
    localparam int DERIV_W    = 34;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET     = 2'd3;

    // limit status codes
    localparam logic [HIT_W-1:0] LIM_NONE = 2'd0;
    localparam logic [HIT_W-1:0] LIM_HIGH = 2'd1;
    localparam logic [HIT_W-1:0] LIM_LOW  = 2'd2;

    // 32-bit drive bounds
    localparam logic signed [OUT_W-1:0] DRIVE_MAX = 32'sh7fff_ffff;
    localparam logic signed [OUT_W-1:0] DRIVE_MIN = 32'sh8000_0000;

    // request and result payloads
    typedef struct packed {
        logic signed [DATA_W-1:0] measured;
        logic        [DATA_W-1:0] time_step;
    } t_pta_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] drive;
        logic        [HIT_W-1:0] limit_hit;
    } t_pta_out;

    // multiplier control
    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] p;
    } t_mul_rsp;

    // divider control
    typedef struct packed {
        logic                 start;
        logic [DIV_MAG_W-1:0] mag;
        logic [DATA_W-1:0]    dvs;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_rsp;

    // clamp a wide signed value to the 48-bit integrator range
    function automatic logic signed [INTEG_W-1:0] sat48(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-INTEG_W:0] top;
        top = x[ACC_W-1:INTEG_W-1];
        if ((&top) || (~|top)) begin
            return x[INTEG_W-1:0];
        end else if (x[ACC_W-1]) begin
            return {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            return {1'b0, {(INTEG_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== hdl/pta_mul.sv =====
module pta_mul
    import pta_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int CNT_W = $clog2(MUL_DIGITS);
    localparam int BX_W  = MUL_DIG_W * MUL_DIGITS;
    localparam int PP_W  = MUL_P_W + MUL_DIG_W + 1;

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [MUL_P_W-1:0]   r_a_sh;
    logic [BX_W-1:0]             r_b_sh;
    logic signed [MUL_P_W-1:0]   r_acc;

    logic signed [MUL_DIG_W:0]   n_digit;
    logic signed [PP_W-1:0]      n_pp;
    logic                        n_last;

    // low digits are unsigned, the top digit carries the sign
    assign n_last  = (r_cnt == CNT_W'(MUL_DIGITS - 1));
    assign n_digit = n_last ? {r_b_sh[MUL_DIG_W-1], r_b_sh[MUL_DIG_W-1:0]}
                            : {1'b0, r_b_sh[MUL_DIG_W-1:0]};
    assign n_pp    = r_a_sh * n_digit;

    // one digit of b per cycle, lsb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a_sh <= MUL_P_W'(i_req.a);
                r_b_sh <= BX_W'(i_req.b);
            end else if (r_busy) begin
                r_acc  <= r_acc + n_pp[MUL_P_W-1:0];
                r_a_sh <= r_a_sh <<< MUL_DIG_W;
                r_b_sh <= r_b_sh >> MUL_DIG_W;
                r_cnt  <= r_cnt + 1'b1;
                if (n_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

    // a new product is never started over one in flight
    a_mul_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiplier started while busy");

endmodule

// ===== hdl/pta_div.sv =====
module pta_div
    import pta_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_Q_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_W-1:0]     r_rem;
    logic [DATA_W-1:0]     r_dvs;
    logic [DIV_Q_W-1:0]    r_q;

    logic [DATA_W:0]       n_trial;
    logic [DATA_W:0]       n_sub;
    logic                  n_ge;

    // restoring step: bring down one dividend bit, try the subtract
    assign n_trial = {r_rem, r_q[DIV_Q_W-1]};
    assign n_sub   = n_trial - {1'b0, r_dvs};
    assign n_ge    = (n_trial >= {1'b0, r_dvs});

    // one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_req.dvs;
                r_q    <= {i_req.mag, {DATA_W{1'b0}}};
            end else if (r_busy) begin
                r_rem <= n_ge ? n_sub[DATA_W-1:0] : n_trial[DATA_W-1:0];
                r_q   <= {r_q[DIV_Q_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    // a new quotient is never started over one in flight
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

endmodule

// ===== hdl/pid_trapezoid_antiwindup.sv =====
// PID controller with trapezoidal integral and anti-windup. Each request (measurement,
// Q8.8 time step) yields one result: the Q24.8 drive, saturated to 32 bits, and a
// limit flag. One request is worked at a time: the next request is taken only once the
// previous one has written its result and the sequencer is idle again. A radix-2 serial
// divider forms the derivative while a radix-16 serial multiplier runs the integral,
// proportional, integral-gain and error-times-step products; three further products
// that need the derivative follow it. A finished result sits in an output register, so
// the next request is taken while it waits. The user must write gains and setpoint
// through the register port only while the block is idle; the block does not enforce
// this. A zero time step gives no integral growth and divides the derivative by one.
module pid_trapezoid_antiwindup
    import pta_pkg::*;
#(
    parameter int OUT_LIMIT = 1023
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_pta_in               i_req,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_pta_out              o_rsp,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DATA_W-1:0]     i_cfg_wdata
);

    localparam logic signed [ACC_W-1:0] LIM     = ACC_W'(OUT_LIMIT * 256);
    localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M_INT,
        S_M_PROP,
        S_M_IGAIN,
        S_M_ET,
        S_WAIT_D,
        S_M_DGAIN,
        S_M_DS,
        S_M_DS2,
        S_FIN
    } t_state;

    t_state                     r_state;
    logic signed [DATA_W-1:0]   r_gain_prop;
    logic signed [DATA_W-1:0]   r_gain_int;
    logic signed [DATA_W-1:0]   r_gain_deriv;
    logic signed [DATA_W-1:0]   r_target;
    logic signed [ERR_W-1:0]    r_last_err;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]    r_err;
    logic [DATA_W-1:0]          r_step;
    logic                       r_dsign;
    logic signed [DERIV_W-1:0]  r_deriv;
    logic                       r_d_rdy;
    logic signed [ACC_W-1:0]    r_drive;
    logic signed [ACC_W-1:0]    r_corr;
    t_mul_req                   r_mul_req;
    t_div_req                   r_div_req;
    logic                       r_o_valid;
    t_pta_out                   r_o_rsp;

    t_mul_rsp                   mul_rsp;
    t_div_rsp                   div_rsp;

    logic signed [ERR_W-1:0]    n_err;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    n_diff;
    logic signed [SUM_W-1:0]    n_diff_neg;
    logic [DIV_MAG_W-1:0]       n_mag;
    logic [DATA_W-1:0]          n_dvs;
    logic signed [DIV_Q_W+1:0]  n_inc;
    logic signed [ACC_W-1:0]    n_pshift;
    logic signed [DERIV_W-1:0]  n_deriv;
    logic                       n_hi;
    logic                       n_lo;
    logic signed [OUT_W-1:0]    n_drive32;

    // error terms of the incoming sample
    assign n_err      = ERR_W'(r_target) - ERR_W'(i_req.measured);
    assign n_sum      = SUM_W'(n_err) + SUM_W'(r_last_err);
    assign n_diff     = SUM_W'(n_err) - SUM_W'(r_last_err);
    assign n_diff_neg = -n_diff;
    assign n_mag      = n_diff[SUM_W-1] ? n_diff_neg[DIV_MAG_W-1:0] : n_diff[DIV_MAG_W-1:0];
    assign n_dvs      = (i_req.time_step == '0) ? DATA_W'(1) : i_req.time_step;

    // product taps: half for the trapezoid, Q.8 realignment for the I, D and second step products
    assign n_inc      = mul_rsp.p[DIV_Q_W+2:1];
    assign n_pshift   = {{(ACC_W - MUL_P_W + 8){mul_rsp.p[MUL_P_W-1]}},
                         mul_rsp.p[MUL_P_W-1:8]};
    assign n_deriv    = r_dsign ? -{1'b0, div_rsp.quot} : {1'b0, div_rsp.quot};

    // limit test and output saturation
    assign n_hi       = (r_drive > LIM);
    assign n_lo       = (r_drive < LIM_NEG);
    always_comb begin
        if ((&r_drive[ACC_W-1:OUT_W-1]) || (~|r_drive[ACC_W-1:OUT_W-1])) begin
            n_drive32 = r_drive[OUT_W-1:0];
        end else if (r_drive[ACC_W-1]) begin
            n_drive32 = DRIVE_MIN;
        end else begin
            n_drive32 = DRIVE_MAX;
        end
    end

    pta_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .o_rsp   (mul_rsp)
    );

    pta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= 16'sd256;
            r_gain_int   <= '0;
            r_gain_deriv <= '0;
            r_target     <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_GAIN_PROP:  r_gain_prop  <= i_cfg_wdata;
                REG_GAIN_INT:   r_gain_int   <= i_cfg_wdata;
                REG_GAIN_DERIV: r_gain_deriv <= i_cfg_wdata;
                REG_TARGET:     r_target     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer over the shared multiplier and the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_last_err      <= '0;
            r_integ         <= '0;
            r_d_rdy         <= 1'b0;
            r_mul_req.start <= 1'b0;
            r_div_req.start <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            r_mul_req.start <= 1'b0;
            r_div_req.start <= 1'b0;
            if (i_ready) begin
                r_o_valid <= 1'b0;
            end

            // signed derivative once the quotient lands
            if (div_rsp.done) begin
                r_deriv <= n_deriv;
                r_d_rdy <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_err           <= n_err;
                        r_step          <= i_req.time_step;
                        r_last_err      <= n_err;
                        r_dsign         <= n_diff[SUM_W-1];
                        r_d_rdy         <= 1'b0;
                        r_mul_req.start <= 1'b1;
                        r_mul_req.a     <= MUL_A_W'(n_sum);
                        r_mul_req.b     <= {1'b0, i_req.time_step};
                        r_div_req.start <= 1'b1;
                        r_div_req.mag   <= n_mag;
                        r_div_req.dvs   <= n_dvs;
                        r_state         <= S_M_INT;
                    end
                end
                S_M_INT: begin
                    if (mul_rsp.done) begin
                        r_integ         <= sat48(ACC_W'(r_integ) + ACC_W'(n_inc));
                        r_mul_req.start <= 1'b1;
                        r_mul_req.a     <= MUL_A_W'(r_err);
                        r_mul_req.b     <= MUL_B_W'(r_gain_prop);
                        r_state         <= S_M_PROP;
                    end
                end
                S_M_PROP: begin
                    if (mul_rsp.done) begin
                        r_drive         <= mul_rsp.p[ACC_W-1:0];
                        r_mul_req.start <= 1'b1;
                        r_mul_req.a     <= r_integ;
                        r_mul_req.b     <= MUL_B_W'(r_gain_int);
                        r_state         <= S_M_IGAIN;
                    end
                end
                S_M_IGAIN: begin
                    if (mul_rsp.done) begin
                        r_drive         <= r_drive + n_pshift;
                        r_mul_req.start <= 1'b1;
                        r_mul_req.a     <= MUL_A_W'(r_err);
                        r_mul_req.b     <= {1'b0, r_step};
                        r_state         <= S_M_ET;
                    end
                end
                S_M_ET: begin
                    if (mul_rsp.done) begin
                        r_corr  <= mul_rsp.p[ACC_W-1:0];
                        r_state <= S_WAIT_D;
                    end
                end
                S_WAIT_D: begin
                    if (r_d_rdy) begin
                        r_mul_req.start <= 1'b1;
                        r_mul_req.a     <= MUL_A_W'(r_deriv);
                        r_mul_req.b     <= MUL_B_W'(r_gain_deriv);
                        r_state         <= S_M_DGAIN;
                    end
                end
                S_M_DGAIN: begin
                    if (mul_rsp.done) begin
                        r_drive         <= r_drive + n_pshift;
                        r_mul_req.start <= 1'b1;
                        r_mul_req.a     <= MUL_A_W'(r_deriv);
                        r_mul_req.b     <= {1'b0, r_step};
                        r_state         <= S_M_DS;
                    end
                end
                S_M_DS: begin
                    // floor(D*s/256) feeds the second step multiply
                    if (mul_rsp.done) begin
                        r_mul_req.start <= 1'b1;
                        r_mul_req.a     <= mul_rsp.p[MUL_A_W+7:8];
                        r_mul_req.b     <= {1'b0, r_step};
                        r_state         <= S_M_DS2;
                    end
                end
                S_M_DS2: begin
                    if (mul_rsp.done) begin
                        r_corr  <= r_corr + n_pshift;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid      <= 1'b1;
                        r_o_rsp.drive  <= n_drive32;
                        if (n_hi) begin
                            r_o_rsp.limit_hit <= LIM_HIGH;
                            r_integ           <= sat48(LIM - r_corr);
                        end else if (n_lo) begin
                            r_o_rsp.limit_hit <= LIM_LOW;
                            r_integ           <= sat48(r_corr - LIM);
                        end else begin
                            r_o_rsp.limit_hit <= LIM_NONE;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_rsp   = r_o_rsp;

    // a taken request launches both serial units on the next cycle
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_mul_req.start && r_div_req.start))
        else $error("request taken without launching the datapath");

    // products only arrive while the sequencer waits for one
    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state != S_IDLE && r_state != S_WAIT_D && r_state != S_FIN))
        else $error("product arrived with no consumer");

    // the quotient is always claimed by a request in progress
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state != S_IDLE && r_state != S_FIN))
        else $error("quotient arrived with no request in progress");

    // limit flag agrees with the sign of the reported drive
    a_hit_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_rsp.limit_hit == LIM_NONE)
                  || (o_rsp.limit_hit == LIM_HIGH && !o_rsp.drive[OUT_W-1] && o_rsp.drive != '0)
                  || (o_rsp.limit_hit == LIM_LOW && o_rsp.drive[OUT_W-1])))
        else $error("limit flag disagrees with drive");

endmodule

// ===== test/pid_trapezoid_antiwindup_chk.sv =====
`timescale 1ns / 100ps

module pid_trapezoid_antiwindup_chk
    import pta_pkg::*;
#(
    parameter int OUT_LIMIT = 1023
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  t_pta_in               i_req,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  t_pta_out              i_rsp,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DATA_W-1:0]     i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam longint INTEG_HI = 64'sh0000_7fff_ffff_ffff;
    localparam longint INTEG_LO = -INTEG_HI - 1;

    // controller copy: gains, setpoint and loop state
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
    logic signed [DATA_W-1:0] setpoint;
    longint                   prev_err;
    longint                   integ_acc;

    t_pta_out drive_expect_q[$];

    // clamp to the 48-bit integrator range
    function automatic longint clamp_integ(input longint x);
        if (x > INTEG_HI) begin
            return INTEG_HI;
        end
        if (x < INTEG_LO) begin
            return INTEG_LO;
        end
        return x;
    endfunction

    // one control step: updates the loop state and returns the expected result
    function automatic t_pta_out predict_drive(input t_pta_in s);
        longint   meas;
        longint   step;
        longint   dvs;
        longint   err;
        longint   dv;
        longint   drv;
        longint   lim;
        longint   corr;
        t_pta_out r;
        meas = s.measured;
        step = s.time_step;
        dvs  = (step == 0) ? 1 : step;
        err  = setpoint - meas;
        lim  = longint'(OUT_LIMIT) * 256;

        // trapezoid integral, derivative truncated toward zero
        integ_acc = clamp_integ(integ_acc + (((err + prev_err) * step) >>> 1));
        dv        = ((err - prev_err) * 65536) / dvs;
        drv       = kp * err + ((ki * integ_acc) >>> 8) + ((kd * dv) >>> 8);
        prev_err  = err;

        // anti-windup rewrite of the integral
        corr        = err * step + ((((dv * step) >>> 8) * step) >>> 8);
        r.limit_hit = LIM_NONE;
        if (drv > lim) begin
            r.limit_hit = LIM_HIGH;
            integ_acc   = clamp_integ(lim - corr);
        end else if (drv < -lim) begin
            r.limit_hit = LIM_LOW;
            integ_acc   = clamp_integ(-lim + corr);
        end

        // 32-bit output saturation
        if (drv > DRIVE_MAX) begin
            drv = DRIVE_MAX;
        end else if (drv < DRIVE_MIN) begin
            drv = DRIVE_MIN;
        end
        r.drive = drv[OUT_W-1:0];
        return r;
    endfunction

    // watch the ports: register writes, results against expectations, new requests
    always @(posedge i_clk) begin
        t_pta_out want;
        if (!i_rst_n) begin
            kp           = 16'sd256;
            ki           = '0;
            kd           = '0;
            setpoint     = '0;
            prev_err     = 0;
            integ_acc    = 0;
            drive_expect_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_GAIN_PROP:  kp       = i_cfg_wdata;
                    REG_GAIN_INT:   ki       = i_cfg_wdata;
                    REG_GAIN_DERIV: kd       = i_cfg_wdata;
                    REG_TARGET:     setpoint = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (drive_expect_q.size() == 0) begin
                    $error("unexpected result: drive %0d, limit_hit %0d",
                           i_rsp.drive, i_rsp.limit_hit);
                    o_fail_count++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (i_rsp.drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d", want.drive, i_rsp.drive);
                        o_fail_count++;
                    end
                    if (i_rsp.limit_hit !== want.limit_hit) begin
                        $error("limit_hit: expected %0d, actual %0d",
                               want.limit_hit, i_rsp.limit_hit);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                drive_expect_q.push_back(predict_drive(i_req));
            end
        end
        o_pending = drive_expect_q.size();
    end

endmodule

// ===== test/pid_trapezoid_antiwindup_tb.sv =====
`timescale 1ns / 100ps

module pid_trapezoid_antiwindup_tb;
    import pta_pkg::*;

    localparam int OUT_LIMIT      = 1023;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 108;
    localparam int MAX_GAP        = 18;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;

    typedef enum int {
        GAINS_SMALL,
        GAINS_RANDOM,
        GAINS_GENTLE,
        GAINS_EXTREME
    } t_gain_mix;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    t_pta_in               req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    t_pta_out              rsp;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DATA_W-1:0]     cfg_wdata;

    int                       fail_count;
    int                       pending;
    int                       quiet_cycles;
    bit                       tx_gaps;
    bit                       rx_gaps;
    bit                       rx_hold;
    logic signed [DATA_W-1:0] cur_target;

    pid_trapezoid_antiwindup #(
        .OUT_LIMIT(OUT_LIMIT)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (req_valid),
        .o_ready    (req_ready),
        .i_req      (req),
        .o_valid    (rsp_valid),
        .i_ready    (rsp_ready),
        .o_rsp      (rsp),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    pid_trapezoid_antiwindup_chk #(
        .OUT_LIMIT(OUT_LIMIT)
    ) u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_req       (req),
        .i_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .i_rsp       (rsp),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 8 ns clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // stall watchdog: cycles with no request, result or register write
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result sink: random stalls, one long hold-off on request
    initial begin : rsp_sink
        int unsigned stall;
        bit          hold_done;
        rsp_ready = 1'b0;
        hold_done = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (rx_hold && !hold_done) begin
                rsp_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            stall = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                rsp_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready = 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // offer one request; returns on the falling edge after it is taken
    task automatic send_sample(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] s);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.measured  = m;
        req.time_step = s;
        req_valid     = 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge clk);
    endtask

    // load all four registers once the block is idle
    task automatic set_regs(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] i,
                            input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] t);
        wait_drained();
        cfg_write(REG_GAIN_PROP, p);
        cfg_write(REG_GAIN_INT, i);
        cfg_write(REG_GAIN_DERIV, d);
        cfg_write(REG_TARGET, t);
        cfg_wr_en  = 1'b0;
        cur_target = t;
    endtask

    function automatic logic [DATA_W-1:0] pick_gain(input t_gain_mix mix);
        case (mix)
            GAINS_SMALL:  return 16'(int'($urandom_range(0, 1024)) - 512);
            GAINS_RANDOM: return 16'($urandom);
            GAINS_GENTLE: return 16'($urandom_range(0, 64));
            default:      return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    // half the samples close to the setpoint, so the loop settles and the integral matters
    function automatic logic [DATA_W-1:0] pick_measured();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return 16'(int'(cur_target) + int'($urandom_range(0, 128)) - 64);
            4, 5:       return 16'($urandom);
            6:          return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            default:    return 16'h0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_step();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return 16'($urandom_range(1, 512));
            4, 5:       return 16'($urandom);
            6:          return 16'h0000;
            default:    return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0001;
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        t_gain_mix         mix;
        logic [DATA_W-1:0] tgt;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        tx_gaps    = 1'b1;
        rx_gaps    = 1'b1;
        rx_hold    = 1'b0;
        cur_target = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // register values out of reset
        send_sample(16'h0000, 16'h0100);
        send_sample(16'hfc18, 16'h0100);
        send_sample(16'h03e8, 16'h0000);

        // moderate gains: zero error, zero step, full-scale swings with the shortest and longest steps
        set_regs(16'h0180, 16'h0040, 16'h0010, 16'h0064);
        send_sample(16'h0064, 16'h0100);
        send_sample(16'h005a, 16'h0100);
        send_sample(16'h0078, 16'h0000);
        send_sample(16'h7fff, 16'h0001);
        send_sample(16'h8000, 16'hffff);
        send_sample(16'h0000, 16'h0001);

        // largest gains and setpoint: drive saturates high
        set_regs(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h0001);
        send_sample(16'h7fff, 16'hffff);
        send_sample(16'h7fff, 16'h0000);

        // most negative gains and setpoint
        set_regs(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h0001);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h0080);

        // gentle gains: drive stays inside the limits
        set_regs(16'h0010, 16'h0001, 16'h0000, 16'h0000);
        send_sample(16'h0002, 16'h0100);
        send_sample(16'hfffd, 16'h0100);
        send_sample(16'h0000, 16'h0200);
        send_sample(16'h0001, 16'hffff);

        // random phases, one of them with a long output hold-off
        for (int ph = 0; ph < PHASES; ph++) begin
            mix = t_gain_mix'($urandom_range(0, 3));
            tgt = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                              : 16'(int'($urandom_range(0, 2000)) - 1000);
            set_regs(pick_gain(mix), pick_gain(mix), pick_gain(mix), tgt);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            if (ph == PHASES / 2) begin
                tx_gaps = 1'b0;
                rx_hold = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(pick_measured(), pick_step());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
